FILE: rtl/tfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared types, codes and constants of the telemetry frame receiver.
// ----------------------------------------------------------------------------
package tfr_pkg;

    localparam int AddrBits  = 5;
    localparam int HeldBytes = 18;

    // byte positions inside a frame
    localparam logic [4:0] PosVersion = 5'd2;
    localparam logic [4:0] PosKind    = 5'd3;
    localparam logic [4:0] PosLength  = 5'd4;
    localparam logic [4:0] PosHeld    = 5'd5;
    localparam logic [4:0] PosHeldEnd = 5'd22;
    localparam logic [4:0] PosCrcLo   = 5'd23;
    localparam logic [4:0] PosCrcHi   = 5'd24;

    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'h1021;
    localparam logic [31:0] IdleCap = 32'hFFFF_0000;

    localparam logic [7:0]  ResetHeaderFirst  = 8'hA5;
    localparam logic [7:0]  ResetHeaderSecond = 8'h5A;
    localparam logic [7:0]  ResetVersion      = 8'd1;
    localparam logic [7:0]  ResetKind         = 8'd1;
    localparam logic [7:0]  ResetLength       = 8'd18;
    localparam logic [15:0] ResetTimeout      = 16'd200;
    localparam logic [7:0]  ResetValidMask    = 8'd1;
    localparam logic [31:0] ResetIdle         = {16'd0, ResetTimeout} + 32'd1;

    typedef enum logic [1:0] {
        OP_BYTE   = 2'd0,
        OP_TICK   = 2'd1,
        OP_RESYNC = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_ACCEPTED = 3'd1,
        EV_HEADER   = 3'd2,
        EV_CRC      = 3'd3,
        EV_STALE    = 3'd4,
        EV_LOST     = 3'd5,
        EV_RESYNC   = 3'd6
    } event_t;

    typedef enum logic [2:0] {
        REG_HEADER_FIRST  = 3'd0,
        REG_HEADER_SECOND = 3'd1,
        REG_VERSION       = 3'd2,
        REG_KIND          = 3'd3,
        REG_LENGTH        = 3'd4,
        REG_TIMEOUT       = 3'd5,
        REG_VALID_MASK    = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [7:0]  header_first;
        logic [7:0]  header_second;
        logic [7:0]  protocol_version;
        logic [7:0]  frame_kind;
        logic [7:0]  payload_length;
        logic [15:0] lost_timeout_ms;
        logic [7:0]  valid_flag_mask;
    } tfr_cfg_t;

    typedef struct packed {
        logic load;       // item accepted this cycle
        logic crc_shift;  // one bit step of the running crc
        logic tick_add;
        logic tick_cmp;
        logic emit;       // load the result register
    } tfr_cmd_t;

    typedef struct packed {
        logic crc_byte;   // incoming item is a byte covered by the crc
        logic tick_op;
    } tfr_status_t;

    typedef struct packed {
        logic [2:0]         event_res;
        logic               link_online;
        logic [15:0]        sequence_res;
        logic [7:0]         frame_flags;
        logic signed [7:0]  zone;
        logic signed [15:0] bearing_err;
        logic [15:0]        target_x;
        logic [15:0]        target_y;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
        logic [15:0]        confidence;
        logic [15:0]        sender_uptime;
    } tfr_result_t;

endpackage

FILE: rtl/tfr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_if
// Item channels of the telemetry frame receiver: input feed and result report.
// ----------------------------------------------------------------------------
interface tfr_feed_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  data_byte;
    logic [15:0] tick_ms;

    modport source (output valid, output opcode, output data_byte, output tick_ms,
                    input ready);
    modport sink (input valid, input opcode, input data_byte, input tick_ms,
                  output ready);
endinterface

interface tfr_report_if;
    logic               valid;
    logic               ready;
    logic [2:0]         event_res;
    logic               link_online;
    logic [15:0]        sequence_res;
    logic [7:0]         frame_flags;
    logic signed [7:0]  zone;
    logic signed [15:0] bearing_err;
    logic [15:0]        target_x;
    logic [15:0]        target_y;
    logic [15:0]        box_width;
    logic [15:0]        box_height;
    logic [15:0]        confidence;
    logic [15:0]        sender_uptime;

    modport source (output valid, output event_res, output link_online,
                    output sequence_res, output frame_flags, output zone,
                    output bearing_err, output target_x, output target_y,
                    output box_width, output box_height, output confidence,
                    output sender_uptime, input ready);
    modport sink (input valid, input event_res, input link_online,
                  input sequence_res, input frame_flags, input zone,
                  input bearing_err, input target_x, input target_y,
                  input box_width, input box_height, input confidence,
                  input sender_uptime, output ready);
endinterface

FILE: rtl/tfr_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_regs
// APB configuration registers: header bytes, frame checks, timeout, flag mask.
// ----------------------------------------------------------------------------
module tfr_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tfr_pkg::AddrBits-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output tfr_pkg::tfr_cfg_t              cfg
);
    import tfr_pkg::*;

    tfr_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[AddrBits-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first     <= ResetHeaderFirst;
            cfg_reg.header_second    <= ResetHeaderSecond;
            cfg_reg.protocol_version <= ResetVersion;
            cfg_reg.frame_kind       <= ResetKind;
            cfg_reg.payload_length   <= ResetLength;
            cfg_reg.lost_timeout_ms  <= ResetTimeout;
            cfg_reg.valid_flag_mask  <= ResetValidMask;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_HEADER_FIRST:  cfg_reg.header_first     <= pwdata[7:0];
                REG_HEADER_SECOND: cfg_reg.header_second    <= pwdata[7:0];
                REG_VERSION:       cfg_reg.protocol_version <= pwdata[7:0];
                REG_KIND:          cfg_reg.frame_kind       <= pwdata[7:0];
                REG_LENGTH:        cfg_reg.payload_length   <= pwdata[7:0];
                REG_TIMEOUT:       cfg_reg.lost_timeout_ms  <= pwdata[15:0];
                REG_VALID_MASK:    cfg_reg.valid_flag_mask  <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_HEADER_FIRST:  prdata = {24'd0, cfg_reg.header_first};
            REG_HEADER_SECOND: prdata = {24'd0, cfg_reg.header_second};
            REG_VERSION:       prdata = {24'd0, cfg_reg.protocol_version};
            REG_KIND:          prdata = {24'd0, cfg_reg.frame_kind};
            REG_LENGTH:        prdata = {24'd0, cfg_reg.payload_length};
            REG_TIMEOUT:       prdata = {16'd0, cfg_reg.lost_timeout_ms};
            REG_VALID_MASK:    prdata = {24'd0, cfg_reg.valid_flag_mask};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/tfr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_ctrl
// Sequencer: takes an item, runs crc bit steps or the tick steps, emits result.
// ----------------------------------------------------------------------------
module tfr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  tfr_pkg::tfr_status_t  st,
    output tfr_pkg::tfr_cmd_t     cmd
);
    import tfr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRC,
        S_TICK_ADD,
        S_TICK_CMP,
        S_EMIT
    } state_t;

    state_t     state_reg;
    logic [2:0] bit_cnt_reg;
    logic       out_valid_reg;
    logic       slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd           = '0;
        cmd.load      = in_ready && in_valid;
        cmd.crc_shift = (state_reg == S_CRC);
        cmd.tick_add  = (state_reg == S_TICK_ADD);
        cmd.tick_cmp  = (state_reg == S_TICK_CMP);
        cmd.emit      = (state_reg == S_EMIT) && slot_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bit_cnt_reg   <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    bit_cnt_reg <= 3'd0;
                    if (in_valid)
                    begin
                        priority if (st.crc_byte)
                            state_reg <= S_CRC;
                        else if (st.tick_op)
                            state_reg <= S_TICK_ADD;
                        else
                            state_reg <= S_EMIT;
                    end
                end
                S_CRC:
                begin
                    bit_cnt_reg <= bit_cnt_reg + 3'd1;
                    // eight bit steps per byte
                    if (bit_cnt_reg == 3'd7)
                        state_reg <= S_EMIT;
                end
                S_TICK_ADD:
                    state_reg <= S_TICK_CMP;
                S_TICK_CMP:
                    state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (slot_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/tfr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_dp
// Datapath: frame parser, running crc, sequence check, idle timer, result.
// ----------------------------------------------------------------------------
module tfr_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tfr_pkg::tfr_cfg_t     cfg,
    input  logic [1:0]            opcode,
    input  logic [7:0]            data_byte,
    input  logic [15:0]           tick_ms,
    input  tfr_pkg::tfr_cmd_t     cmd,
    output tfr_pkg::tfr_status_t  st,
    output tfr_pkg::tfr_result_t  result
);
    import tfr_pkg::*;

    logic [4:0]  count_reg;
    logic [15:0] crc_reg;
    logic [7:0]  crc_lo_reg;
    logic [7:0]  stage_reg [HeldBytes];
    logic [7:0]  held_reg [HeldBytes];
    logic [15:0] last_seq_reg;
    logic        seq_known_reg;
    logic [31:0] idle_reg;
    logic        online_reg;
    logic [15:0] ms_reg;
    event_t      event_reg;
    tfr_result_t result_reg;

    logic        is_byte;
    logic [15:0] crc_base;
    logic [15:0] stage_seq;
    logic [15:0] seq_diff;
    logic        seq_behind;
    logic        crc_ok;
    logic        now_online;

    assign is_byte     = (opcode == OP_BYTE);
    assign st.crc_byte = is_byte && (count_reg >= PosVersion) && (count_reg <= PosHeldEnd);
    assign st.tick_op  = (opcode == OP_TICK);

    assign crc_base   = (count_reg == PosVersion) ? CrcInit : crc_reg;
    assign stage_seq  = {stage_reg[1], stage_reg[0]};
    assign seq_diff   = stage_seq - last_seq_reg;
    // newer under wraparound means a forward distance below half the range
    assign seq_behind = seq_known_reg && ((seq_diff == 16'd0) || seq_diff[15]);
    assign crc_ok     = (crc_reg == {data_byte, crc_lo_reg});
    assign now_online = (idle_reg <= {16'd0, cfg.lost_timeout_ms});

    assign result = result_reg;

    // payload bytes staged for the held copy, and the low crc byte
    always_ff @(posedge clk)
    begin
        if (cmd.load && is_byte)
        begin
            for (int k = 0; k < HeldBytes; k++)
            begin
                if (count_reg == PosHeld + 5'(k))
                    stage_reg[k] <= data_byte;
            end
            if (count_reg == PosCrcLo)
                crc_lo_reg <= data_byte;
        end
    end

    // bit-serial crc, msb first
    always_ff @(posedge clk)
    begin
        if (cmd.load && st.crc_byte)
            crc_reg <= crc_base ^ {data_byte, 8'd0};
        else if (cmd.crc_shift)
            crc_reg <= {crc_reg[14:0], 1'b0} ^ (crc_reg[15] ? CrcPoly : 16'd0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            ms_reg <= tick_ms;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 5'd0;
            last_seq_reg  <= 16'd0;
            seq_known_reg <= 1'b0;
            idle_reg      <= ResetIdle;
            online_reg    <= 1'b0;
            event_reg     <= EV_NONE;
            for (int k = 0; k < HeldBytes; k++)
                held_reg[k] <= 8'd0;
        end
        else if (cmd.load)
        begin
            priority if (opcode == OP_RESYNC)
            begin
                count_reg <= 5'd0;
                event_reg <= EV_RESYNC;
            end
            else if (is_byte)
            begin
                priority if (count_reg == 5'd0)
                begin
                    event_reg <= EV_NONE;
                    if (data_byte == cfg.header_first)
                        count_reg <= 5'd1;
                end
                else if (count_reg == 5'd1)
                begin
                    event_reg <= EV_NONE;
                    priority if (data_byte == cfg.header_second)
                        count_reg <= PosVersion;
                    else if (data_byte == cfg.header_first)
                        count_reg <= 5'd1;
                    else
                        count_reg <= 5'd0;
                end
                else if (count_reg == PosVersion)
                begin
                    if (data_byte == cfg.protocol_version)
                    begin
                        count_reg <= PosKind;
                        event_reg <= EV_NONE;
                    end
                    else
                    begin
                        count_reg <= 5'd0;
                        event_reg <= EV_HEADER;
                    end
                end
                else if (count_reg == PosKind)
                begin
                    if (data_byte == cfg.frame_kind)
                    begin
                        count_reg <= PosLength;
                        event_reg <= EV_NONE;
                    end
                    else
                    begin
                        count_reg <= 5'd0;
                        event_reg <= EV_HEADER;
                    end
                end
                else if (count_reg == PosLength)
                begin
                    if (data_byte == cfg.payload_length)
                    begin
                        count_reg <= PosHeld;
                        event_reg <= EV_NONE;
                    end
                    else
                    begin
                        count_reg <= 5'd0;
                        event_reg <= EV_HEADER;
                    end
                end
                else if (count_reg <= PosCrcLo)
                begin
                    count_reg <= count_reg + 5'd1;
                    event_reg <= EV_NONE;
                end
                else if (count_reg == PosCrcHi)
                begin
                    count_reg <= 5'd0;
                    priority if (!crc_ok)
                        event_reg <= EV_CRC;
                    else if (seq_behind)
                        event_reg <= EV_STALE;
                    else
                    begin
                        event_reg     <= EV_ACCEPTED;
                        last_seq_reg  <= stage_seq;
                        seq_known_reg <= 1'b1;
                        for (int k = 0; k < HeldBytes; k++)
                            held_reg[k] <= stage_reg[k];
                        // a frame flagged as carrying a target restarts the idle timer
                        if ((stage_reg[2] & cfg.valid_flag_mask) != 8'd0)
                            idle_reg <= 32'd0;
                    end
                end
                else
                begin
                    count_reg <= 5'd0;
                    event_reg <= EV_NONE;
                end
            end
            else
                event_reg <= EV_NONE;
        end
        else if (cmd.tick_add)
        begin
            if (idle_reg < IdleCap)
                idle_reg <= idle_reg + {16'd0, ms_reg};
        end
        else if (cmd.tick_cmp)
        begin
            online_reg <= now_online;
            if (online_reg && !now_online)
            begin
                seq_known_reg <= 1'b0;
                event_reg     <= EV_LOST;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.event_res     <= event_reg;
            result_reg.link_online   <= online_reg;
            result_reg.sequence_res  <= {held_reg[1], held_reg[0]};
            result_reg.frame_flags   <= held_reg[2];
            result_reg.zone          <= held_reg[3];
            result_reg.bearing_err   <= {held_reg[5], held_reg[4]};
            result_reg.target_x      <= {held_reg[7], held_reg[6]};
            result_reg.target_y      <= {held_reg[9], held_reg[8]};
            result_reg.box_width     <= {held_reg[11], held_reg[10]};
            result_reg.box_height    <= {held_reg[13], held_reg[12]};
            result_reg.confidence    <= {held_reg[15], held_reg[14]};
            result_reg.sender_uptime <= {held_reg[17], held_reg[16]};
        end
    end

endmodule

FILE: rtl/telemetry_frame_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_frame_receiver_unit
// Serial telemetry deframer with crc-16 check, sequence filter and link timer.
// ----------------------------------------------------------------------------
// channel   dir   handshake            carries
// feed      in    valid/ready          opcode, data_byte, tick_ms
// report    out   valid/ready          event, link state, last accepted frame
// apb       in    psel/penable/pready  configuration registers at 4*index
//
// a frame byte between version and last payload byte runs accept, eight steps
// of the bit-serial crc, emit; a tick runs accept, add, compare, emit; other items accept, emit.
// one item is in work at a time; the next item is taken while
// the previous result still waits in the report register. a full report
// register holds the sequencer in its emit step. rst_n clears parser and
// link state and sets the idle timer past the reset timeout, at once.
// ----------------------------------------------------------------------------
module telemetry_frame_receiver_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tfr_pkg::AddrBits-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    tfr_feed_if.sink                      feed,
    tfr_report_if.source                  report
);
    import tfr_pkg::*;

    tfr_cfg_t    cfg;
    tfr_cmd_t    cmd;
    tfr_status_t st;
    tfr_result_t result;

    tfr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (feed.valid),
        .in_ready  (feed.ready),
        .out_valid (report.valid),
        .out_ready (report.ready),
        .st        (st),
        .cmd       (cmd)
    );

    tfr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .opcode    (feed.opcode),
        .data_byte (feed.data_byte),
        .tick_ms   (feed.tick_ms),
        .cmd       (cmd),
        .st        (st),
        .result    (result)
    );

    assign report.event_res     = result.event_res;
    assign report.link_online   = result.link_online;
    assign report.sequence_res  = result.sequence_res;
    assign report.frame_flags   = result.frame_flags;
    assign report.zone          = result.zone;
    assign report.bearing_err   = result.bearing_err;
    assign report.target_x      = result.target_x;
    assign report.target_y      = result.target_y;
    assign report.box_width     = result.box_width;
    assign report.box_height    = result.box_height;
    assign report.confidence    = result.confidence;
    assign report.sender_uptime = result.sender_uptime;

endmodule

FILE: sim/tfr_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_tb_pkg
// Frame type and crc helper shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package tfr_tb_pkg;

    import tfr_pkg::*;

    localparam int FrameBytes = 25;

    // opcode value with no meaning, the block must ignore it
    localparam logic [1:0] OpUnused = 2'd3;

    typedef logic [FrameBytes-1:0][7:0] frame_t;

    // crc-16/ccitt-false over version byte through last payload byte
    function automatic logic [15:0] frame_crc(input frame_t f);
        logic [15:0] crc;
        int          i;
        int          b;
        crc = CrcInit;
        for (i = int'(PosVersion); i <= int'(PosHeldEnd); i++)
        begin
            crc = crc ^ {f[i], 8'h00};
            for (b = 0; b < 8; b++)
            begin
                crc = crc[15] ? ((crc << 1) ^ CrcPoly) : (crc << 1);
            end
        end
        return crc;
    endfunction

endpackage

FILE: sim/tfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_checker
// Watches the feed, report and register channels, predicts every report of
// the telemetry frame receiver and compares it with the one the block sends.
// ----------------------------------------------------------------------------
module tfr_checker
    import tfr_pkg::*;
    import tfr_tb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [AddrBits-1:0]  paddr,
    input  logic [31:0]          pwdata,
    tfr_feed_if                  feed,
    tfr_report_if                report,
    output int unsigned          mismatches,
    output int unsigned          awaiting,
    output int unsigned          results_checked,
    output int unsigned          frames_taken,
    output int unsigned          links_lost
);

    localparam int MaxReports = 10;

    tfr_cfg_t     cfg;
    frame_t       frame_q;
    logic [4:0]   fill;
    logic [15:0]  last_seq;
    logic         seq_known;
    logic [31:0]  idle_ms;
    logic         online;
    logic [7:0]   held [HeldBytes];
    tfr_result_t  due_reports [$];

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MaxReports)
        begin
            $display("%s", what);
        end
    endfunction

    function automatic string describe(input tfr_result_t r);
        return {$sformatf("ev=%0d online=%0b seq=%h flags=%h zone=%0d steer=%0d ",
                          r.event_res, r.link_online, r.sequence_res, r.frame_flags,
                          r.zone, r.bearing_err),
                $sformatf("x=%h y=%h w=%h h=%h conf=%h run=%h",
                          r.target_x, r.target_y, r.box_width, r.box_height,
                          r.confidence, r.sender_uptime)};
    endfunction

    // sequence filter and snapshot of a frame whose crc passed
    function automatic event_t judge_frame();
        logic [15:0] seq;
        logic [15:0] ahead;
        int          i;
        seq = {frame_q[6], frame_q[5]};
        if (seq_known)
        begin
            ahead = seq - last_seq;
            if (ahead == 16'd0 || ahead[15])
            begin
                return EV_STALE;
            end
        end
        last_seq  = seq;
        seq_known = 1'b1;
        for (i = 0; i < HeldBytes; i++)
        begin
            held[i] = frame_q[int'(PosHeld) + i];
        end
        if ((frame_q[7] & cfg.valid_flag_mask) != 8'd0)
        begin
            idle_ms = 32'd0;
        end
        return EV_ACCEPTED;
    endfunction

    function automatic event_t deframe_byte(input logic [7:0] b);
        if (fill == 5'd0 && b != cfg.header_first)
        begin
            return EV_NONE;
        end
        if (fill == 5'd1 && b != cfg.header_second)
        begin
            // a second copy of the first header byte restarts the frame
            if (b == cfg.header_first)
            begin
                frame_q[0] = b;
                fill       = 5'd1;
            end
            else
            begin
                fill = 5'd0;
            end
            return EV_NONE;
        end
        frame_q[fill] = b;
        fill          = fill + 5'd1;
        if ((fill == 5'd3 && b != cfg.protocol_version) ||
            (fill == 5'd4 && b != cfg.frame_kind) ||
            (fill == 5'd5 && b != cfg.payload_length))
        begin
            fill = 5'd0;
            return EV_HEADER;
        end
        if (fill == 5'(FrameBytes))
        begin
            fill = 5'd0;
            if (frame_crc(frame_q) == {frame_q[PosCrcHi], frame_q[PosCrcLo]})
            begin
                return judge_frame();
            end
            return EV_CRC;
        end
        return EV_NONE;
    endfunction

    function automatic event_t advance_idle(input logic [15:0] ms);
        logic   now_online;
        event_t ev;
        ev = EV_NONE;
        if (idle_ms < IdleCap)
        begin
            idle_ms = idle_ms + {16'd0, ms};
        end
        now_online = (idle_ms <= {16'd0, cfg.lost_timeout_ms});
        if (online && !now_online)
        begin
            seq_known = 1'b0;
            ev        = EV_LOST;
        end
        online = now_online;
        return ev;
    endfunction

    function automatic tfr_result_t link_report(input event_t ev);
        tfr_result_t r;
        r.event_res     = ev;
        r.link_online   = online;
        r.sequence_res  = {held[1], held[0]};
        r.frame_flags   = held[2];
        r.zone          = held[3];
        r.bearing_err   = {held[5], held[4]};
        r.target_x      = {held[7], held[6]};
        r.target_y      = {held[9], held[8]};
        r.box_width     = {held[11], held[10]};
        r.box_height    = {held[13], held[12]};
        r.confidence    = {held[15], held[14]};
        r.sender_uptime = {held[17], held[16]};
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tfr_result_t got;
        tfr_result_t want;
        event_t      ev;
        int          i;
        if (!rst_n)
        begin
            cfg.header_first     = ResetHeaderFirst;
            cfg.header_second    = ResetHeaderSecond;
            cfg.protocol_version = ResetVersion;
            cfg.frame_kind       = ResetKind;
            cfg.payload_length   = ResetLength;
            cfg.lost_timeout_ms  = ResetTimeout;
            cfg.valid_flag_mask  = ResetValidMask;
            frame_q   = '0;
            fill      = 5'd0;
            last_seq  = 16'd0;
            seq_known = 1'b0;
            idle_ms   = ResetIdle;
            online    = 1'b0;
            for (i = 0; i < HeldBytes; i++)
            begin
                held[i] = 8'd0;
            end
            due_reports.delete();
            mismatches      = 0;
            awaiting        = 0;
            results_checked = 0;
            frames_taken    = 0;
            links_lost      = 0;
        end
        else
        begin
            // the report leaving now belongs to an earlier item, so check it first
            if (report.valid && report.ready)
            begin
                got.event_res     = report.event_res;
                got.link_online   = report.link_online;
                got.sequence_res  = report.sequence_res;
                got.frame_flags   = report.frame_flags;
                got.zone          = report.zone;
                got.bearing_err   = report.bearing_err;
                got.target_x      = report.target_x;
                got.target_y      = report.target_y;
                got.box_width     = report.box_width;
                got.box_height    = report.box_height;
                got.confidence    = report.confidence;
                got.sender_uptime = report.sender_uptime;
                if (due_reports.size() == 0)
                begin
                    note_mismatch($sformatf("report with nothing due: %s", describe(got)));
                end
                else
                begin
                    want = due_reports.pop_front();
                    results_checked++;
                    if (got !== want)
                    begin
                        note_mismatch($sformatf("report mismatch\n  expected %s\n  actual   %s",
                                                describe(want), describe(got)));
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[AddrBits-1:2]))
                    REG_HEADER_FIRST:  cfg.header_first     = pwdata[7:0];
                    REG_HEADER_SECOND: cfg.header_second    = pwdata[7:0];
                    REG_VERSION:       cfg.protocol_version = pwdata[7:0];
                    REG_KIND:          cfg.frame_kind       = pwdata[7:0];
                    REG_LENGTH:        cfg.payload_length   = pwdata[7:0];
                    REG_TIMEOUT:       cfg.lost_timeout_ms  = pwdata[15:0];
                    REG_VALID_MASK:    cfg.valid_flag_mask  = pwdata[7:0];
                    default:           ;
                endcase
            end
            if (feed.valid && feed.ready)
            begin
                if (feed.opcode == OP_BYTE)
                begin
                    ev = deframe_byte(feed.data_byte);
                end
                else if (feed.opcode == OP_TICK)
                begin
                    ev = advance_idle(feed.tick_ms);
                end
                else if (feed.opcode == OP_RESYNC)
                begin
                    fill = 5'd0;
                    ev   = EV_RESYNC;
                end
                else
                begin
                    ev = EV_NONE;
                end
                if (ev == EV_ACCEPTED)
                begin
                    frames_taken++;
                end
                if (ev == EV_LOST)
                begin
                    links_lost++;
                end
                due_reports.push_back(link_report(ev));
            end
            awaiting = due_reports.size();
        end
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the telemetry frame receiver: well-formed frames with random
// content mixed with broken frames, noise, ticks and resyncs, over several
// register settings. Sender gaps and receiver stalls are random; the checker
// beside the block predicts and compares every report.
// ----------------------------------------------------------------------------
module tb_top;

    import tfr_pkg::*;
    import tfr_tb_pkg::*;

    localparam int MaxGap        = 20;
    localparam int MaxStall      = 24;
    localparam int WatchdogLimit = 2000;
    localparam int SettleCycles  = 16;
    localparam int DrainCycles   = 40;
    localparam int BigTicks      = 16;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [AddrBits-1:0]  paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    int unsigned mismatches;
    int unsigned awaiting;
    int unsigned results_checked;
    int unsigned frames_taken;
    int unsigned links_lost;

    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned idle_cycles = 0;
    logic        tx_steady   = 1'b0;
    logic        rx_open     = 1'b0;
    logic [15:0] seq_head    = 16'd0;
    tfr_cfg_t    cfg_shadow;

    tfr_feed_if   feed_ch ();
    tfr_report_if report_ch ();

    telemetry_frame_receiver_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .feed    (feed_ch),
        .report  (report_ch)
    );

    tfr_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .feed            (feed_ch),
        .report          (report_ch),
        .mismatches      (mismatches),
        .awaiting        (awaiting),
        .results_checked (results_checked),
        .frames_taken    (frames_taken),
        .links_lost      (links_lost)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: open and stalled stretches of random length
    initial
    begin
        int unsigned hold;
        logic        level;
        hold            = 0;
        level           = 1'b0;
        report_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_open)
            begin
                report_ch.ready = 1'b1;
            end
            else
            begin
                if (hold == 0)
                begin
                    level = ($urandom_range(0, 2) != 0);
                    hold  = level ? $urandom_range(1, 30) : $urandom_range(1, MaxStall);
                end
                hold--;
                report_ch.ready = level;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((feed_ch.valid && feed_ch.ready) || (report_ch.valid && report_ch.ready) ||
            (psel && penable))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // entered and left just after a falling edge
    task automatic send_item(input logic [1:0] op, input logic [7:0] b,
                             input logic [15:0] ms);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = 0;
            if (!tx_steady && $urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, MaxGap);
            end
            if (gap != 0)
            begin
                feed_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        feed_ch.valid     = 1'b1;
        feed_ch.opcode    = op;
        feed_ch.data_byte = b;
        feed_ch.tick_ms   = ms;
        @(posedge clk);
        while (!feed_ch.ready)
        begin
            @(posedge clk);
        end
        burst_left--;
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(OP_BYTE, b, 16'($urandom));
    endtask

    task automatic send_tick(input logic [15:0] ms);
        send_item(OP_TICK, 8'($urandom), ms);
    endtask

    task automatic send_frame(input frame_t f);
        int i;
        for (i = 0; i < FrameBytes; i++)
        begin
            send_byte(f[i]);
        end
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_HEADER_FIRST:  cfg_shadow.header_first     = value[7:0];
            REG_HEADER_SECOND: cfg_shadow.header_second    = value[7:0];
            REG_VERSION:       cfg_shadow.protocol_version = value[7:0];
            REG_KIND:          cfg_shadow.frame_kind       = value[7:0];
            REG_LENGTH:        cfg_shadow.payload_length   = value[7:0];
            REG_TIMEOUT:       cfg_shadow.lost_timeout_ms  = value[15:0];
            REG_VALID_MASK:    cfg_shadow.valid_flag_mask  = value[7:0];
            default:           ;
        endcase
    endtask

    // hold the feed and let every report drain before touching registers
    task automatic settle();
        feed_ch.valid = 1'b0;
        while (awaiting != 0)
        begin
            @(negedge clk);
        end
        repeat (SettleCycles) @(negedge clk);
    endtask

    function automatic frame_t make_frame(input logic [15:0] seq, input logic [7:0] flags);
        frame_t      f;
        logic [15:0] crc;
        int          i;
        for (i = 0; i < FrameBytes; i++)
        begin
            f[i] = 8'($urandom);
        end
        f[0]        = cfg_shadow.header_first;
        f[1]        = cfg_shadow.header_second;
        f[PosVersion] = cfg_shadow.protocol_version;
        f[PosKind]    = cfg_shadow.frame_kind;
        f[PosLength]  = cfg_shadow.payload_length;
        f[5]        = seq[7:0];
        f[6]        = seq[15:8];
        f[7]        = flags;
        crc         = frame_crc(f);
        f[PosCrcLo] = crc[7:0];
        f[PosCrcHi] = crc[15:8];
        return f;
    endfunction

    function automatic logic [7:0] pick_flags();
        logic [7:0] flags;
        flags = 8'($urandom);
        if ($urandom_range(0, 9) < 7)
        begin
            flags = flags | cfg_shadow.valid_flag_mask;
        end
        else
        begin
            flags = flags & ~cfg_shadow.valid_flag_mask;
        end
        return flags;
    endfunction

    function automatic logic [15:0] pick_tick();
        case ($urandom_range(0, 9))
            0, 1, 2: return 16'd0;
            3:       return 16'($urandom);
            4:       return cfg_shadow.lost_timeout_ms;
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    task automatic random_episode();
        frame_t      f;
        int unsigned pick;
        int unsigned k;
        int unsigned n;
        logic [15:0] seq;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            seq = seq_head + 16'd1;
            if ($urandom_range(0, 9) == 0)
            begin
                seq = seq_head + 16'($urandom_range(1, 16'h7FFF));
            end
            send_frame(make_frame(seq, pick_flags()));
            seq_head = seq;
        end
        else if (pick < 53)
        begin
            // same, older, or exactly half the sequence space ahead
            seq = seq_head - 16'($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0)
            begin
                seq = seq_head + 16'h8000;
            end
            send_frame(make_frame(seq, pick_flags()));
        end
        else if (pick < 61)
        begin
            f    = make_frame(seq_head + 16'd1, pick_flags());
            k    = $urandom_range(int'(PosHeld), int'(PosCrcHi));
            f[k] = f[k] ^ 8'($urandom_range(1, 255));
            send_frame(f);
        end
        else if (pick < 67)
        begin
            f    = make_frame(seq_head + 16'd1, pick_flags());
            k    = $urandom_range(int'(PosVersion), int'(PosLength));
            f[k] = f[k] ^ 8'($urandom_range(1, 255));
            send_frame(f);
        end
        else if (pick < 71)
        begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(cfg_shadow.header_first);
            seq = seq_head + 16'd1;
            send_frame(make_frame(seq, pick_flags()));
            seq_head = seq;
        end
        else if (pick < 75)
        begin
            // cut a frame short, sometimes followed by a resync
            f = make_frame(seq_head + 16'd1, pick_flags());
            n = $urandom_range(1, FrameBytes - 1);
            for (k = 0; k < n; k++)
            begin
                send_byte(f[k]);
            end
            if ($urandom_range(0, 1) == 1)
            begin
                send_item(OP_RESYNC, 8'($urandom), 16'($urandom));
            end
        end
        else if (pick < 85)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_tick(pick_tick());
        end
        else if (pick < 92)
        begin
            n = $urandom_range(1, 8);
            repeat (n) send_byte(8'($urandom));
        end
        else if (pick < 96)
        begin
            send_item(OP_RESYNC, 8'($urandom), 16'($urandom));
        end
        else
        begin
            send_item(OpUnused, 8'($urandom), 16'($urandom));
        end
    endtask

    task automatic run_phase(input int unsigned quota);
        int unsigned stop_at;
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            random_episode();
        end
        settle();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = 32'd0;
        feed_ch.valid     = 1'b0;
        feed_ch.opcode    = OP_BYTE;
        feed_ch.data_byte = 8'd0;
        feed_ch.tick_ms   = 16'd0;
        cfg_shadow.header_first     = ResetHeaderFirst;
        cfg_shadow.header_second    = ResetHeaderSecond;
        cfg_shadow.protocol_version = ResetVersion;
        cfg_shadow.frame_kind       = ResetKind;
        cfg_shadow.payload_length   = ResetLength;
        cfg_shadow.lost_timeout_ms  = ResetTimeout;
        cfg_shadow.valid_flag_mask  = ResetValidMask;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: ignored opcode, resync, tick extremes, stray bytes,
        // a repeated first header byte, each header field wrong, timeout edge
        send_item(OpUnused, 8'hFF, 16'hFFFF);
        send_item(OP_RESYNC, 8'h00, 16'h0000);
        send_tick(16'd0);
        send_tick(16'hFFFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(cfg_shadow.header_first);
        send_byte(cfg_shadow.header_first);
        send_byte(cfg_shadow.header_second);
        send_byte(8'h00);
        send_byte(cfg_shadow.header_first);
        send_byte(cfg_shadow.header_second);
        send_byte(cfg_shadow.protocol_version);
        send_byte(8'hFF);
        send_byte(cfg_shadow.header_first);
        send_byte(cfg_shadow.header_second);
        send_byte(cfg_shadow.protocol_version);
        send_byte(cfg_shadow.frame_kind);
        send_byte(8'h00);
        send_frame(make_frame(16'hFFFF, 8'hFF));
        seq_head = 16'hFFFF;
        send_tick(cfg_shadow.lost_timeout_ms);
        send_tick(16'd1);
        settle();

        run_phase(110);

        write_reg(REG_HEADER_FIRST, 32'h00);
        write_reg(REG_HEADER_SECOND, 32'hFF);
        write_reg(REG_VERSION, 32'h00);
        write_reg(REG_KIND, 32'hFF);
        write_reg(REG_LENGTH, 32'h00);
        write_reg(REG_TIMEOUT, 32'h0);
        write_reg(REG_VALID_MASK, 32'hFF);
        run_phase(110);

        // both header bytes equal, longest timeout, no flag counts as valid
        write_reg(REG_HEADER_FIRST, 32'hFF);
        write_reg(REG_HEADER_SECOND, 32'hFF);
        write_reg(REG_VERSION, 32'hFF);
        write_reg(REG_KIND, 32'h00);
        write_reg(REG_LENGTH, 32'hFF);
        write_reg(REG_TIMEOUT, 32'hFFFF);
        write_reg(REG_VALID_MASK, 32'h00);
        run_phase(90);

        write_reg(REG_HEADER_FIRST, 32'($urandom_range(0, 255)));
        write_reg(REG_HEADER_SECOND, 32'($urandom_range(0, 255)));
        write_reg(REG_VERSION, 32'($urandom_range(0, 255)));
        write_reg(REG_KIND, 32'($urandom_range(0, 255)));
        write_reg(REG_LENGTH, 32'($urandom_range(0, 255)));
        write_reg(REG_TIMEOUT, 32'($urandom_range(1, 400)));
        write_reg(REG_VALID_MASK, 32'd1 << $urandom_range(0, 7));
        run_phase(110);

        // longest timeout, a fresh frame, then back to back large ticks
        write_reg(REG_TIMEOUT, 32'hFFFF);
        write_reg(REG_VALID_MASK, 32'h01);
        tx_steady = 1'b1;
        rx_open   = 1'b1;
        send_frame(make_frame(seq_head + 16'd1, 8'h01));
        send_tick(16'd0);
        repeat (BigTicks) send_tick(16'hFFFF);
        send_tick(16'd0);
        tx_steady = 1'b0;
        rx_open   = 1'b0;

        feed_ch.valid = 1'b0;
        while (awaiting != 0)
        begin
            @(negedge clk);
        end
        repeat (DrainCycles) @(negedge clk);

        $display("covered %0d items over five register settings, %0d reports checked",
                 items_sent, results_checked);
        $display("frames accepted %0d, link losses %0d, mismatches %0d, left over %0d",
                 frames_taken, links_lost, mismatches, awaiting);
        if (mismatches == 0 && awaiting == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
